// File: rtl/dual_stack_shared_memory_top_macros.svh
// Assertion macros used by the checker file of the dual stack block.
`ifndef DUAL_STACK_SHARED_MEMORY_TOP_MACROS_SVH
`define DUAL_STACK_SHARED_MEMORY_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSSM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dual stack check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dual stack check failed");

`endif

// File: rtl/dssm_pkg.sv
// Package with the constants, codes and word types of the dual stack block.
package dssm_pkg;

  localparam int unsigned Depth = 128;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic               which_stack;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [7:0]         selected_length;
    logic               all_empty;
  } out_word_t;

endpackage

// File: rtl/dual_stack_shared_memory_top.sv
// Two stacks sharing one synchronous memory, left growing up and right growing down.
//
// Usage: the input channel (in_valid_i, in_ready_o, in_data_i) takes one word holding an
// operation (push, pop or peek), the stack it selects and the value to push. The output
// channel (out_valid_o, out_ready_i, out_data_o) returns exactly one word per input word,
// in order, with the read value, a status, the selected stack's length and a flag that
// both stacks are empty.
// The input word addresses the memory port in the cycle it is accepted; the read data is
// registered, and the result word then loads into the output register. The block takes no
// new word until the current one has moved into the output register.
// The result sits in an output register; a new word is accepted while it waits. If the
// receiver stalls, the next item holds in its read stage until the output register frees.
// Reset empties both stacks at once; the memory contents are not cleared and no
// clearing pass runs.
module dual_stack_shared_memory_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dssm_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dssm_pkg::out_word_t  out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [31:0] mem_q [dssm_pkg::Depth];
  logic [31:0] rdata_q;

  logic [dssm_pkg::CntW-1:0] left_q, left_d, right_q, right_d;
  logic [dssm_pkg::CntW:0]   total;
  logic [dssm_pkg::CntW-1:0] sel_cnt, sel_cnt_new;
  logic [dssm_pkg::CntW-1:0] right_push_pos, right_top_pos, left_top_pos;
  logic [dssm_pkg::AddrW-1:0] addr;
  logic                       wr_en, rd_en;

  logic [1:0]        pend_status_q, pend_status_d;
  logic              pend_mem_q, pend_mem_d;
  logic [31:0]       pend_value_q, pend_value_d;
  logic [7:0]        pend_len_q, pend_len_d;
  logic              pend_empty_q, pend_empty_d;

  dssm_pkg::out_word_t out_q;
  logic                out_valid_q;
  logic                accept, out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_READ) && (!out_valid_q || out_ready_i);

  assign total          = {1'b0, left_q} + {1'b0, right_q};
  assign sel_cnt        = in_data_i.which_stack ? right_q : left_q;
  assign right_push_pos = dssm_pkg::CntW'(dssm_pkg::Depth - 1) - right_q;
  assign right_top_pos  = dssm_pkg::CntW'(dssm_pkg::Depth) - right_q;
  assign left_top_pos   = left_q - dssm_pkg::CntW'(1);

  always_comb begin
    left_d        = left_q;
    right_d       = right_q;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    addr          = '0;
    pend_status_d = dssm_pkg::ST_OK;
    pend_mem_d    = 1'b0;
    pend_value_d  = '0;
    if (accept) begin
      unique case (in_data_i.kind)
        dssm_pkg::KIND_PUSH: begin
          if (total >= (dssm_pkg::CntW + 1)'(dssm_pkg::Depth)) begin
            pend_status_d = dssm_pkg::ST_FULL;
          end else if (in_data_i.which_stack) begin
            wr_en   = 1'b1;
            addr    = right_push_pos[dssm_pkg::AddrW-1:0];
            right_d = right_q + dssm_pkg::CntW'(1);
          end else begin
            wr_en  = 1'b1;
            addr   = left_q[dssm_pkg::AddrW-1:0];
            left_d = left_q + dssm_pkg::CntW'(1);
          end
        end
        dssm_pkg::KIND_POP, dssm_pkg::KIND_PEEK: begin
          if (sel_cnt == '0) begin
            pend_status_d = dssm_pkg::ST_EMPTY;
            pend_value_d  = '1;
          end else begin
            rd_en      = 1'b1;
            pend_mem_d = 1'b1;
            addr       = in_data_i.which_stack ? right_top_pos[dssm_pkg::AddrW-1:0]
                                               : left_top_pos[dssm_pkg::AddrW-1:0];
            if (in_data_i.kind == dssm_pkg::KIND_POP) begin
              if (in_data_i.which_stack) begin
                right_d = right_q - dssm_pkg::CntW'(1);
              end else begin
                left_d = left_q - dssm_pkg::CntW'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    sel_cnt_new  = in_data_i.which_stack ? right_d : left_d;
    pend_len_d   = 8'(sel_cnt_new);
    pend_empty_d = (left_d == '0) && (right_d == '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= in_data_i.push_value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      left_q      <= '0;
      right_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      right_q <= right_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q <= pend_status_d;
      pend_mem_q    <= pend_mem_d;
      pend_value_q  <= pend_value_d;
      pend_len_q    <= pend_len_d;
      pend_empty_q  <= pend_empty_d;
    end
    if (out_load) begin
      out_q.read_value      <= pend_mem_q ? rdata_q : pend_value_q;
      out_q.status          <= pend_status_q;
      out_q.selected_length <= pend_len_q;
      out_q.all_empty       <= pend_empty_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/dssm_checker.sv
// Port-level checker of the dual stack block and its bind to the top level.
`include "dual_stack_shared_memory_top_macros.svh"

module dssm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input dssm_pkg::in_word_t   in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input dssm_pkg::out_word_t  out_data_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  `DSSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `DSSM_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_acc, !in_ready_o)
  `DSSM_ASSERT_NOW(a_empty_value, clk_i, rst_ni,
                   out_valid_o && out_data_o.status == dssm_pkg::ST_EMPTY,
                   out_data_o.read_value == -32'sd1)
  `DSSM_ASSERT_NOW(a_full_value, clk_i, rst_ni,
                   out_valid_o && out_data_o.status == dssm_pkg::ST_FULL,
                   out_data_o.read_value == 32'sd0)
  `DSSM_ASSERT_NOW(a_empty_len, clk_i, rst_ni, out_valid_o && out_data_o.all_empty,
                   out_data_o.selected_length == 8'd0)

endmodule

bind dual_stack_shared_memory_top dssm_checker u_dssm_checker (.*);
